// ===== hw/rtl/rkl_pkg.sv =====
package rkl_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int K_RANK_W   = 7;
    localparam int IN_VALUE_W = 32;
    localparam int OUT_W      = 32;

    localparam logic [K_RANK_W-1:0] K_RANK_RESET = K_RANK_W'(1);

    // Control bits handed from one cell to the next
    typedef struct packed {
        logic gt;     // incoming value belongs at or above this cell
        logic valid;  // cell holds a kept value for the current transaction
    } link_t;

endpackage

// ===== hw/rtl/rkl_cell.sv =====
module rkl_cell #(
    parameter int INDEX      = 0,
    parameter int VALUE_BITS = 32,
    parameter int CMP_W      = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  clear,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [CMP_W-1:0]      k_eff,
    input  rkl_pkg::link_t        prev_link,
    input  logic [VALUE_BITS-1:0] prev_value,
    output rkl_pkg::link_t        link,
    output logic [VALUE_BITS-1:0] value,
    output logic                  kept,
    output logic                  is_last
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  live;
    logic                  valid_cur;
    logic                  gt;

    assign live      = IDX < k_eff;
    assign is_last   = IDX == (k_eff - CMP_W'(1));
    assign valid_cur = valid_reg & live & ~clear;
    // equal values stay above the newcomer
    assign gt        = ~valid_cur | (in_value > value_reg);

    assign link.gt    = gt;
    assign link.valid = valid_cur;
    assign value      = value_reg;
    // stored entry, independent of the transaction on offer
    assign kept       = valid_reg & live;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg & live;
        if (accept) begin
            valid_next = valid_cur;
            if (live && gt) begin
                if (prev_link.gt) begin
                    // shift down from the neighbor
                    value_next = prev_value;
                    valid_next = prev_link.valid;
                end else begin
                    // insertion point
                    value_next = in_value;
                    valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== hw/rtl/running_kth_largest.sv =====
// Running k-th largest: keeps the k largest values of an unsigned stream in a
// row of MAX_RANK compare-and-shift cells, largest first, and after each input
// transaction from the k-th of a stream on, returns the k-th largest value seen
// so far. Earlier transactions of a stream return nothing. Setting the tuser bit
// (first_of_stream) empties the store before that value is taken. The rank is
// written on the cfg port (0 acts as 1, above MAX_RANK acts as MAX_RANK). The
// user must write it only while the block is idle; the block does not enforce
// this. Lowering it drops the entries beyond the new rank. Throughput is one
// transaction per clock while m_tready stays high: every cell compares the new
// value against its own entry and takes the new value or its neighbor's entry
// in the same cycle. The result is read from the cell that holds rank k and
// registered on the m_ side. With m_tready low, one more transaction enters a
// one-deep hold stage; then s_tready drops until the waiting result is taken.
module running_kth_largest #(
    parameter int MAX_RANK   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: rank k
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rkl_pkg::K_RANK_W-1:0]  cfg_data,    // [6:0] k_rank
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rkl_pkg::IN_VALUE_W-1:0] s_tdata,    // [31:0] value
    input  logic [0:0]                    s_tuser,     // [0] first_of_stream
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rkl_pkg::OUT_W-1:0]     m_tdata      // [31:0] kth_largest
);

    localparam int RANK_W = $clog2(MAX_RANK + 1);
    localparam int CMP_W  = (RANK_W > rkl_pkg::K_RANK_W) ? RANK_W : rkl_pkg::K_RANK_W;
    localparam logic [CMP_W-1:0] MAX_K = CMP_W'(MAX_RANK);

    logic [rkl_pkg::K_RANK_W-1:0] k_rank_reg;
    logic [rkl_pkg::K_RANK_W-1:0] k_rank_next;
    logic [CMP_W-1:0]             k_wide;
    logic [CMP_W-1:0]             k_eff;

    logic                  pend_reg;
    logic                  pend_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [rkl_pkg::OUT_W-1:0] m_tdata_reg;
    logic [rkl_pkg::OUT_W-1:0] m_tdata_next;

    logic                  accept;
    logic                  advance;
    logic [VALUE_BITS-1:0] in_value;

    rkl_pkg::link_t        links  [MAX_RANK+1];
    logic [VALUE_BITS-1:0] values [MAX_RANK+1];
    logic [MAX_RANK-1:0]   kept_vec;
    logic [MAX_RANK-1:0]   last_vec;
    logic [VALUE_BITS-1:0] sel_value;
    logic                  sel_valid;
    logic [rkl_pkg::OUT_W-1:0] sel_out;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        k_rank_next = k_rank_reg;
        if (cfg_valid && cfg_ready) begin
            k_rank_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_rank_reg <= rkl_pkg::K_RANK_RESET;
        end else begin
            k_rank_reg <= k_rank_next;
        end
    end

    // clamp the rank into 1..MAX_RANK
    assign k_wide = CMP_W'(k_rank_reg);
    always_comb begin
        if (k_wide == '0) begin
            k_eff = CMP_W'(1);
        end else if (k_wide > MAX_K) begin
            k_eff = MAX_K;
        end else begin
            k_eff = k_wide;
        end
    end

    // ---------------- input side ----------------
    // advance the held result whenever the output register is free or being read
    assign advance  = ~m_tvalid_reg | m_tready;
    assign s_tready = ~pend_reg | advance;
    assign accept   = s_tvalid & s_tready;

    generate
        if (VALUE_BITS <= rkl_pkg::IN_VALUE_W) begin : g_in_narrow
            assign in_value = s_tdata[VALUE_BITS-1:0];
        end else begin : g_in_wide
            assign in_value = {{(VALUE_BITS - rkl_pkg::IN_VALUE_W){1'b0}}, s_tdata};
        end
    endgenerate

    // ---------------- cell row ----------------
    // the head of the row sees no neighbor above it
    assign links[0].gt    = 1'b0;
    assign links[0].valid = 1'b0;
    assign values[0]      = '0;

    generate
        for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
            rkl_cell #(
                .INDEX      (i),
                .VALUE_BITS (VALUE_BITS),
                .CMP_W      (CMP_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .accept     (accept),
                .clear      (s_tuser[0]),
                .in_value   (in_value),
                .k_eff      (k_eff),
                .prev_link  (links[i]),
                .prev_value (values[i]),
                .link       (links[i+1]),
                .value      (values[i+1]),
                .kept       (kept_vec[i]),
                .is_last    (last_vec[i])
            );
        end
    endgenerate

    // pick the entry at rank k (exactly one cell flags itself); read the stored
    // valid bit so a first-of-stream flag on the next offer does not hide it
    always_comb begin
        sel_value = '0;
        sel_valid = 1'b0;
        for (int i = 0; i < MAX_RANK; i++) begin
            sel_value = sel_value | (values[i+1] & {VALUE_BITS{last_vec[i]}});
            sel_valid = sel_valid | (kept_vec[i] & last_vec[i]);
        end
    end

    generate
        if (VALUE_BITS >= rkl_pkg::OUT_W) begin : g_out_narrow
            assign sel_out = sel_value[rkl_pkg::OUT_W-1:0];
        end else begin : g_out_wide
            assign sel_out = {{(rkl_pkg::OUT_W - VALUE_BITS){1'b0}}, sel_value};
        end
    endgenerate

    // ---------------- result side ----------------
    always_comb begin
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (advance) begin
            // drop a taken result, then move the held transaction forward
            m_tvalid_next = 1'b0;
            if (pend_reg) begin
                m_tvalid_next = sel_valid;
                m_tdata_next  = sel_out;
            end
            pend_next = 1'b0;
        end
        if (accept) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    // a new result comes only from a held transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pend_reg))
        else $error("result without a held transaction");

    // input stalls only when both the hold stage and the output are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (pend_reg && m_tvalid && !m_tready))
        else $error("input stalled without cause");

    // exactly one cell reports rank k
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(last_vec))
        else $error("rank select not one-hot");

    // at rank one every accepted transaction yields a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && advance && k_eff == CMP_W'(1)) |=> m_tvalid)
        else $error("rank one transaction gave no result");

endmodule
